// ----- src/sdt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sdt_pkg;

   localparam int unsigned MaxEntries = 16;
   localparam int unsigned IdxW = $clog2(MaxEntries);
   localparam int unsigned CntW = $clog2(MaxEntries + 1);

   localparam logic [15:0] TtlReset = 16'd3000;
   localparam logic [15:0] PeriodReset = 16'd100;
   localparam logic [15:0] MinPduLen = 16'd32;
   localparam logic [7:0] TypeOffer = 8'h01;

   typedef enum logic [3:0] {
      MODE_FIND = 4'd0,
      MODE_OFFER = 4'd1,
      MODE_STOP = 4'd2,
      MODE_SUBSCRIBE = 4'd3,
      MODE_QUERY = 4'd4,
      MODE_RX = 4'd5,
      MODE_TICK = 4'd6,
      MODE_INIT = 4'd7,
      MODE_DEINIT = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      AV_DOWN = 2'd0,
      AV_UP = 2'd1,
      AV_GONE = 2'd2
   } avail_type;

   typedef enum logic [0:0] {
      CSR_TTL_RELOAD = 1'b0,
      CSR_OFFER_PERIOD = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [3:0] mode;
      logic [15:0] service_id;
      logic [15:0] instance_id;
      logic [7:0] msg_type;
      logic [7:0] entry_type;
      logic [15:0] pdu_length;
   } req_type;

   typedef struct packed {
      logic status;
      logic [1:0] service_state;
      logic sub_pending;
      logic [4:0] entry_count;
      logic [15:0] session_id;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // capture request beat
      logic scan_start;  // clear scan pointer and hit mark
      logic scan_step;   // compare one entry, advance pointer on a miss
      logic tick_start;  // advance tick phase, clear pointer
      logic tick_step;   // update one entry on a tick
      logic finish;      // apply the request and build the result
   } sdt_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic tick_done;
      logic active;      // table initialised and serving
   } sdt_sts_type;

endpackage
`default_nettype wire

// ----- src/sdt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface sdt_if #(
   parameter int unsigned Width = 8
);
   logic valid;
   logic ready;
   logic [Width-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/sdt_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sdt_datapath
   import sdt_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire req_type req_data,
   input wire sdt_cmd_type cmd,
   input wire logic [15:0] ttl_reload,
   input wire logic [15:0] offer_period,
   output sdt_sts_type sts,
   output rsp_type rsp_data
);

   logic [15:0] svc_ff [MaxEntries];
   logic [15:0] inst_ff [MaxEntries];
   logic [1:0] avail_ff [MaxEntries];
   logic server_ff [MaxEntries];
   logic subp_ff [MaxEntries];
   logic [15:0] ttl_ff [MaxEntries];

   req_type req_ff;
   logic [CntW-1:0] used_ff;
   logic [15:0] session_ff;
   logic [15:0] phase_ff;
   logic active_ff;
   logic [CntW-1:0] ptr_ff;
   logic hit_ff;
   logic [IdxW-1:0] hit_idx_ff;
   logic fire_ff;
   rsp_type rsp_ff;

   logic [IdxW-1:0] ptr_idx;
   logic [15:0] key_inst;
   logic match;
   logic [15:0] phase_inc;
   logic [15:0] ttl_dec;
   logic up_after;
   logic room;
   logic [IdxW-1:0] new_idx;

   assign ptr_idx = ptr_ff[IdxW-1:0];
   assign key_inst = (req_ff.mode == MODE_SUBSCRIBE) ? 16'd0 : req_ff.instance_id;
   assign match = (svc_ff[ptr_idx] == req_ff.service_id) && (inst_ff[ptr_idx] == key_inst);
   assign phase_inc = phase_ff + 16'd1;
   assign ttl_dec = ttl_ff[ptr_idx] - 16'd1;
   assign room = (used_ff < CntW'(MaxEntries));
   assign new_idx = used_ff[IdxW-1:0];

   assign sts.scan_done = hit_ff || (ptr_ff >= used_ff);
   assign sts.tick_done = (ptr_ff >= used_ff);
   assign sts.active = active_ff;
   assign rsp_data = rsp_ff;

   // entry state after the countdown of this tick step
   always_comb begin
      up_after = (avail_ff[ptr_idx] == AV_UP);
      if (avail_ff[ptr_idx] == AV_UP && ttl_ff[ptr_idx] != 16'd0 && ttl_dec == 16'd0) begin
         up_after = 1'b0;
      end
   end

   // control state and scan bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         session_ff <= 16'd1;
         phase_ff <= '0;
         active_ff <= 1'b1;
         ptr_ff <= '0;
         hit_ff <= 1'b0;
         fire_ff <= 1'b0;
      end else begin
         if (cmd.scan_start) begin
            ptr_ff <= '0;
            hit_ff <= 1'b0;
         end
         if (cmd.scan_step && !sts.scan_done) begin
            if (match) begin
               hit_ff <= 1'b1;
               hit_idx_ff <= ptr_idx;
            end else begin
               ptr_ff <= ptr_ff + 1'b1;
            end
         end
         if (cmd.tick_start) begin
            ptr_ff <= '0;
            hit_ff <= 1'b0;
            if (phase_inc >= offer_period) begin
               phase_ff <= '0;
               fire_ff <= 1'b1;
            end else begin
               phase_ff <= phase_inc;
               fire_ff <= 1'b0;
            end
         end
         if (cmd.tick_step && !sts.tick_done) begin
            ptr_ff <= ptr_ff + 1'b1;
            if (fire_ff && server_ff[ptr_idx] && up_after) begin
               session_ff <= session_ff + 16'd1;
            end
         end
         if (cmd.finish) begin
            unique case (req_ff.mode)
               MODE_FIND: begin
                  if (active_ff && !hit_ff && room) begin
                     used_ff <= used_ff + 1'b1;
                     session_ff <= session_ff + 16'd1;
                  end
               end
               MODE_OFFER: begin
                  if (active_ff && (hit_ff || room)) begin
                     session_ff <= session_ff + 16'd1;
                     if (!hit_ff) begin
                        used_ff <= used_ff + 1'b1;
                     end
                  end
               end
               MODE_INIT: begin
                  used_ff <= '0;
                  session_ff <= 16'd1;
                  phase_ff <= '0;
                  active_ff <= 1'b1;
               end
               MODE_DEINIT: begin
                  active_ff <= 1'b0;
                  used_ff <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // entry table: tick updates and request updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxEntries; i++) begin
            svc_ff[i] <= '0;
            inst_ff[i] <= '0;
            avail_ff[i] <= AV_DOWN;
            server_ff[i] <= 1'b0;
            subp_ff[i] <= 1'b0;
            ttl_ff[i] <= '0;
         end
      end else begin
         if (cmd.tick_step && !sts.tick_done) begin
            if (avail_ff[ptr_idx] == AV_UP && ttl_ff[ptr_idx] != 16'd0) begin
               ttl_ff[ptr_idx] <= ttl_dec;
               if (ttl_dec == 16'd0) begin
                  avail_ff[ptr_idx] <= AV_GONE;
               end
            end
            if (fire_ff && server_ff[ptr_idx] && up_after) begin
               server_ff[ptr_idx] <= 1'b1;
               avail_ff[ptr_idx] <= AV_UP;
               ttl_ff[ptr_idx] <= ttl_reload;
            end
         end
         if (cmd.finish) begin
            unique case (req_ff.mode)
               MODE_FIND: begin
                  if (active_ff && !hit_ff && room) begin
                     svc_ff[new_idx] <= req_ff.service_id;
                     inst_ff[new_idx] <= req_ff.instance_id;
                     avail_ff[new_idx] <= AV_DOWN;
                     server_ff[new_idx] <= 1'b0;
                     subp_ff[new_idx] <= 1'b0;
                     ttl_ff[new_idx] <= '0;
                  end
               end
               MODE_OFFER: begin
                  if (active_ff && hit_ff) begin
                     server_ff[hit_idx_ff] <= 1'b1;
                     avail_ff[hit_idx_ff] <= AV_UP;
                     ttl_ff[hit_idx_ff] <= ttl_reload;
                  end else if (active_ff && room) begin
                     svc_ff[new_idx] <= req_ff.service_id;
                     inst_ff[new_idx] <= req_ff.instance_id;
                     avail_ff[new_idx] <= AV_UP;
                     server_ff[new_idx] <= 1'b1;
                     subp_ff[new_idx] <= 1'b0;
                     ttl_ff[new_idx] <= ttl_reload;
                  end
               end
               MODE_STOP: begin
                  if (active_ff && hit_ff) begin
                     avail_ff[hit_idx_ff] <= AV_GONE;
                     ttl_ff[hit_idx_ff] <= '0;
                  end
               end
               MODE_SUBSCRIBE: begin
                  if (active_ff && hit_ff) begin
                     subp_ff[hit_idx_ff] <= 1'b1;
                  end
               end
               MODE_RX: begin
                  if (hit_ff) begin
                     avail_ff[hit_idx_ff] <= AV_UP;
                     ttl_ff[hit_idx_ff] <= ttl_reload;
                  end
               end
               MODE_INIT: begin
                  for (int i = 0; i < MaxEntries; i++) begin
                     svc_ff[i] <= '0;
                     inst_ff[i] <= '0;
                     avail_ff[i] <= AV_DOWN;
                     server_ff[i] <= 1'b0;
                     subp_ff[i] <= 1'b0;
                     ttl_ff[i] <= '0;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // result word, built from the state before this edge's update
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.status <= 1'b1;
         rsp_ff.service_state <= AV_DOWN;
         rsp_ff.sub_pending <= 1'b0;
         rsp_ff.entry_count <= 5'(used_ff);
         rsp_ff.session_id <= session_ff;
         unique case (req_ff.mode)
            MODE_FIND: begin
               if (active_ff && hit_ff) begin
                  rsp_ff.status <= 1'b0;
                  rsp_ff.service_state <= avail_ff[hit_idx_ff];
                  rsp_ff.sub_pending <= subp_ff[hit_idx_ff];
               end else if (active_ff && room) begin
                  rsp_ff.status <= 1'b0;
                  rsp_ff.entry_count <= 5'(used_ff + 1'b1);
                  rsp_ff.session_id <= session_ff + 16'd1;
               end
            end
            MODE_OFFER: begin
               if (active_ff && (hit_ff || room)) begin
                  rsp_ff.status <= 1'b0;
                  rsp_ff.service_state <= AV_UP;
                  rsp_ff.session_id <= session_ff + 16'd1;
                  if (hit_ff) begin
                     rsp_ff.sub_pending <= subp_ff[hit_idx_ff];
                  end else begin
                     rsp_ff.entry_count <= 5'(used_ff + 1'b1);
                  end
               end
            end
            MODE_STOP: begin
               if (active_ff && hit_ff) begin
                  rsp_ff.status <= 1'b0;
                  rsp_ff.service_state <= AV_GONE;
                  rsp_ff.sub_pending <= subp_ff[hit_idx_ff];
               end
            end
            MODE_SUBSCRIBE: begin
               if (active_ff && hit_ff) begin
                  rsp_ff.status <= 1'b0;
                  rsp_ff.service_state <= avail_ff[hit_idx_ff];
                  rsp_ff.sub_pending <= 1'b1;
               end
            end
            MODE_QUERY: begin
               if (hit_ff) begin
                  rsp_ff.status <= 1'b0;
                  rsp_ff.service_state <= avail_ff[hit_idx_ff];
                  rsp_ff.sub_pending <= subp_ff[hit_idx_ff];
               end
            end
            MODE_RX: begin
               if (hit_ff) begin
                  rsp_ff.status <= 1'b0;
                  rsp_ff.service_state <= AV_UP;
                  rsp_ff.sub_pending <= subp_ff[hit_idx_ff];
               end
            end
            MODE_TICK: begin
               rsp_ff.status <= !active_ff;
            end
            MODE_INIT: begin
               rsp_ff.status <= 1'b0;
               rsp_ff.entry_count <= '0;
               rsp_ff.session_id <= 16'd1;
            end
            MODE_DEINIT: begin
               rsp_ff.status <= 1'b0;
               rsp_ff.entry_count <= '0;
            end
            default: begin
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- src/sdt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sdt_ctrl
   import sdt_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic active,
   input wire sdt_sts_type sts,
   output sdt_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_SCAN = 6'b000100,
      ST_TICK = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_RESULT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   req_type req_ff;
   logic rx_ok;
   logic lookup_mode;

   assign rx_ok = (req_ff.pdu_length >= MinPduLen) && (req_ff.msg_type == TypeOffer)
      && (req_ff.entry_type == TypeOffer);

   // which requests need a table search
   always_comb begin
      case (req_ff.mode)
         MODE_FIND, MODE_OFFER, MODE_STOP, MODE_SUBSCRIBE: lookup_mode = active;
         MODE_QUERY: lookup_mode = 1'b1;
         MODE_RX: lookup_mode = rx_ok;
         default: lookup_mode = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_RESULT);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (lookup_mode) begin
               cmd.scan_start = 1'b1;
               state_in = ST_SCAN;
            end else if (req_ff.mode == MODE_TICK && active) begin
               cmd.tick_start = 1'b1;
               state_in = ST_TICK;
            end else begin
               cmd.scan_start = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_TICK: begin
            cmd.tick_step = 1'b1;
            if (sts.tick_done) begin
               cmd.scan_start = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/service_discovery_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | beat payload
// req     | in  | mode, service_id, instance_id, msg_type, entry_type, pdu_length
// rsp     | out | status, service_state, sub_pending, entry_count, session_id
// csr     | in  | csr_we, csr_index, csr_wdata (ttl_reload, offer_period)
// one request at a time: accept, decode, walk, finish, result
// a search walks entries one a cycle up to the fill count or the first hit
// a tick walks all entries in use one a cycle
// reset is synchronous; the table clears at once, no clearing pass
// a stalled result holds the block; the next beat is taken after it leaves
module service_discovery_table
   import sdt_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   sdt_if.sink req,
   sdt_if.source rsp,
   input wire logic csr_we,
   input wire logic [0:0] csr_index,
   input wire logic [15:0] csr_wdata
);

   logic [15:0] ttl_reload_ff;
   logic [15:0] offer_period_ff;
   sdt_cmd_type cmd;
   sdt_sts_type sts;
   req_type req_data;
   rsp_type rsp_data;
   logic active;

   assign req_data = req_type'(req.data);
   assign rsp.data = rsp_data;
   assign active = sts.active;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_reload_ff <= TtlReset;
         offer_period_ff <= PeriodReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TTL_RELOAD: ttl_reload_ff <= csr_wdata;
            CSR_OFFER_PERIOD: offer_period_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   sdt_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .req_data(req_data),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .active(active),
      .sts(sts),
      .cmd(cmd)
   );

   sdt_datapath u_dp (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .cmd(cmd),
      .ttl_reload(ttl_reload_ff),
      .offer_period(offer_period_ff),
      .sts(sts),
      .rsp_data(rsp_data)
   );

   // no new beat while a result waits
   assert property (@(posedge clock) disable iff (reset) rsp.valid |-> !req.ready)
      else $error("request taken while a result is pending");
   // a result beat returns the block to accepting
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready) |=> req.ready)
      else $error("block not idle after result");
   // entry count never exceeds the table
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.data[20:16] <= 5'(MaxEntries)))
      else $error("entry count out of range");

endmodule
`default_nettype wire
